// ----- rtl/pbc_pkg.sv -----
// Package: shared types and constants of the provisioning backoff controller.
`timescale 1ns / 1ps

package pbc_pkg;

    // Controller phases
    typedef enum logic [1:0] {
        PH_INITIAL = 2'd0,
        PH_ENABLE  = 2'd1,
        PH_NEXT    = 2'd2
    } phase_t;

    // Profile type codes
    localparam logic [1:0] PROF_OTHER = 2'd0;
    localparam logic [1:0] PROF_PROV  = 2'd1;
    localparam logic [1:0] PROF_OPER  = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 22;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_WAIT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_WAIT   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WAIT      = 2'd3;

    // Register reset values
    localparam logic [15:0] INITIAL_WAIT_RESET = 16'd3600;
    localparam logic [15:0] ENABLE_WAIT_RESET  = 16'd600;
    localparam logic [21:0] MAX_WAIT_RESET     = 22'd21600;

    localparam logic [31:0] TICK_COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [4:0]  ATTEMPT_RESET  = 5'd1;

    typedef struct packed {
        logic        block_enable;
        logic [15:0] initial_wait_seconds;
        logic [15:0] enable_wait_seconds;
        logic [21:0] max_wait_seconds;
    } cfg_t;

    // backoff_seconds holds the backoff period in seconds; the tick limit is
    // that value divided by the tick length, compared as a product instead.
    typedef struct packed {
        phase_t      phase;
        logic [31:0] tick_count;
        logic [4:0]  attempt_number;
        logic [31:0] backoff_seconds;
    } state_t;

    typedef struct packed {
        logic       network_enable;
        logic       network_disable;
        logic       request_seed_update;
        logic       request_card_disable;
        logic [1:0] phase_now;
    } result_t;

endpackage

// ----- rtl/pbc_if.sv -----
// Interfaces: configuration write, tick input and action output channels.
`timescale 1ns / 1ps

interface pbc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pbc_pkg::CFG_INDEX_W-1:0]  index;
    logic [pbc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface pbc_tick_if;
    logic       valid;
    logic       ready;
    logic [1:0] profile_type;

    modport source (output valid, profile_type, input ready);
    modport sink   (input valid, profile_type, output ready);
endinterface

interface pbc_action_if;
    logic       valid;
    logic       ready;
    logic       network_enable;
    logic       network_disable;
    logic       request_seed_update;
    logic       request_card_disable;
    logic [1:0] phase_now;

    modport source (output valid, network_enable, network_disable, request_seed_update,
                    request_card_disable, phase_now, input ready);
    modport sink   (input valid, network_enable, network_disable, request_seed_update,
                    request_card_disable, phase_now, output ready);
endinterface

// ----- rtl/pbc_tick.sv -----
// Tick logic: next controller state and action bits for one tick.
`timescale 1ns / 1ps

module pbc_tick #(
    parameter int TICK_SECONDS = 10,
    parameter int MAX_ATTEMPTS = 16
) (
    input  pbc_pkg::cfg_t    cfg,
    input  pbc_pkg::state_t  state,
    input  logic [1:0]       profile_type,
    output pbc_pkg::state_t  state_next,
    output pbc_pkg::result_t result
);

    localparam int TW = $clog2(TICK_SECONDS + 1);
    localparam int PW = 32 + TW;

    logic [PW-1:0] secs_now;     // tick_count * TICK_SECONDS
    logic [PW:0]   secs_after;   // (tick_count + 1) * TICK_SECONDS
    logic [3:0]    shift;
    logic [31:0]   tn;
    logic [31:0]   backoff_eff;
    logic          t_is_one;
    logic          zero_t;
    logic          prov;
    logic          oper;
    pbc_pkg::phase_t ph;

    assign secs_now   = PW'(state.tick_count) * PW'(TICK_SECONDS);
    assign secs_after = (PW+1)'(secs_now) + (PW+1)'(TICK_SECONDS);
    assign shift      = 4'(state.attempt_number - 5'd1);
    // shift <= 15, so the period always fits in 32 bits
    assign tn         = (32'(cfg.initial_wait_seconds) << shift)
                        + 32'(cfg.enable_wait_seconds);
    assign t_is_one   = (state.tick_count == 32'd1);
    assign backoff_eff = t_is_one ? tn : state.backoff_seconds;
    assign prov       = (profile_type == pbc_pkg::PROF_PROV);
    assign oper       = (profile_type == pbc_pkg::PROF_OPER);

    always_comb
    begin
        state_next = state;
        result     = '0;
        ph         = state.phase;
        zero_t     = 1'b0;

        if (cfg.block_enable)
        begin
            unique case (state.phase)
                pbc_pkg::PH_ENABLE:
                begin
                    if (t_is_one)
                    begin
                        result.network_enable      = 1'b1;
                        result.request_seed_update = 1'b1;
                    end
                    // t >= enable_wait / TICK  <=>  enable_wait < (t+1)*TICK
                    else if ((PW+1)'(cfg.enable_wait_seconds) < secs_after && prov)
                    begin
                        ph     = pbc_pkg::PH_NEXT;
                        zero_t = 1'b1;
                    end
                end
                pbc_pkg::PH_NEXT:
                begin
                    if (t_is_one)
                    begin
                        state_next.backoff_seconds = tn;
                        if (tn > 32'(cfg.max_wait_seconds))
                        begin
                            ph     = pbc_pkg::PH_INITIAL;
                            zero_t = 1'b1;
                            state_next.attempt_number = pbc_pkg::ATTEMPT_RESET;
                        end
                        else
                        begin
                            result.network_disable      = 1'b1;
                            result.request_card_disable = 1'b1;
                            if (state.attempt_number < 5'(MAX_ATTEMPTS))
                                state_next.attempt_number = state.attempt_number + 5'd1;
                            else
                                state_next.attempt_number = 5'(MAX_ATTEMPTS);
                        end
                    end
                    // t > backoff / TICK  <=>  backoff < t*TICK
                    if (!zero_t && PW'(backoff_eff) < secs_now)
                    begin
                        ph     = pbc_pkg::PH_ENABLE;
                        zero_t = 1'b1;
                    end
                end
                default:
                begin
                    // initial wait; the unused phase code behaves the same
                    ph = pbc_pkg::PH_INITIAL;
                    if ((PW+1)'(cfg.initial_wait_seconds) < secs_after)
                    begin
                        if (prov)
                            ph = pbc_pkg::PH_NEXT;
                        else if (!oper)
                            ph = pbc_pkg::PH_ENABLE;
                        zero_t = 1'b1;
                    end
                end
            endcase

            if (oper)
            begin
                result.network_enable = 1'b1;
                zero_t                = 1'b1;
            end

            state_next.phase = ph;
            if (zero_t)
                state_next.tick_count = 32'd1;
            else if (state.tick_count != pbc_pkg::TICK_COUNT_MAX)
                state_next.tick_count = state.tick_count + 32'd1;
        end

        result.phase_now = ph;
    end

endmodule

// ----- rtl/provisioning_backoff_controller_core.sv -----
// Top level: provisioning backoff controller with config port and action output register.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake       | Payload
// ---------+-----+-----------------+-------------------------------------------
// cfg      | in  | valid / ready   | index (register 0..3), data (22 bits)
// tick     | in  | valid / ready   | profile_type
// action   | out | valid / ready   | enable/disable pulses, seed and card
//          |     |                 | requests, phase_now
//
// One tick transaction per clock. Its action is held in the output register
// and shown the cycle after acceptance. tick.ready is high whenever that
// register is empty or is being drained, so a stalled action stalls ticks
// only while it is actually blocked. The longest path is the tick count times
// TICK_SECONDS multiply followed by a compare. cfg is always ready.
// Reset loads the register defaults, clears the state and empties the output.

module provisioning_backoff_controller_core #(
    parameter int TICK_SECONDS = 10,
    parameter int MAX_ATTEMPTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    pbc_cfg_if.sink            cfg,
    pbc_tick_if.sink           tick,
    pbc_action_if.source       action
);

    pbc_pkg::cfg_t    cfg_reg;
    pbc_pkg::state_t  state_reg;
    pbc_pkg::state_t  state_next;
    pbc_pkg::result_t result_next;
    pbc_pkg::result_t result_reg;
    logic             valid_reg;
    logic             tick_accept;

    assign cfg.ready   = 1'b1;
    assign tick.ready  = !valid_reg || action.ready;
    assign tick_accept = tick.valid && tick.ready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_enable         <= 1'b0;
            cfg_reg.initial_wait_seconds <= pbc_pkg::INITIAL_WAIT_RESET;
            cfg_reg.enable_wait_seconds  <= pbc_pkg::ENABLE_WAIT_RESET;
            cfg_reg.max_wait_seconds     <= pbc_pkg::MAX_WAIT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pbc_pkg::CFG_BLOCK_ENABLE: cfg_reg.block_enable         <= cfg.data[0];
                pbc_pkg::CFG_INITIAL_WAIT: cfg_reg.initial_wait_seconds <= cfg.data[15:0];
                pbc_pkg::CFG_ENABLE_WAIT:  cfg_reg.enable_wait_seconds  <= cfg.data[15:0];
                pbc_pkg::CFG_MAX_WAIT:     cfg_reg.max_wait_seconds     <= cfg.data;
            endcase
        end
    end

    pbc_tick #(
        .TICK_SECONDS (TICK_SECONDS),
        .MAX_ATTEMPTS (MAX_ATTEMPTS)
    ) u_tick (
        .cfg          (cfg_reg),
        .state        (state_reg),
        .profile_type (tick.profile_type),
        .state_next   (state_next),
        .result       (result_next)
    );

    // Controller state advances once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase           <= pbc_pkg::PH_INITIAL;
            state_reg.tick_count      <= '0;
            state_reg.attempt_number  <= pbc_pkg::ATTEMPT_RESET;
            state_reg.backoff_seconds <= '0;
        end
        else if (tick_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (tick_accept)
            valid_reg <= 1'b1;
        else if (action.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
            result_reg <= result_next;
    end

    assign action.valid                = valid_reg;
    assign action.network_enable       = result_reg.network_enable;
    assign action.network_disable      = result_reg.network_disable;
    assign action.request_seed_update  = result_reg.request_seed_update;
    assign action.request_card_disable = result_reg.request_card_disable;
    assign action.phase_now            = result_reg.phase_now;

    // Card disable and network disable are issued together
    a_disable_pair: assert property (@(posedge clk) disable iff (!rst_n)
        action.valid |-> (action.network_disable == action.request_card_disable))
        else $error("network_disable without matching card disable");

    // A tick with the block off leaves the state alone
    a_hold_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_accept && !cfg_reg.block_enable) |=> $stable(state_reg))
        else $error("state changed while block disabled");

    // Attempt number stays in 1..MAX_ATTEMPTS
    a_attempt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.attempt_number != 5'd0)
        && (state_reg.attempt_number <= 5'(MAX_ATTEMPTS)))
        else $error("attempt number out of range");

    // Every accepted tick yields an action in the next cycle
    a_tick_to_action: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> action.valid)
        else $error("accepted tick produced no action");

endmodule

// ----- tb/tb.sv -----
// Testbench: directed and random ticks and register writes, every action checked against a predicted or given value.
`timescale 1ns / 1ps

module tb;

    localparam int TICK_S    = 10;
    localparam int MAX_ATT   = 16;
    localparam int RUN_ITEMS = 1900;
    // Slowest run: ~1950 ticks, each after the longest idle gap on the send side and the longest
    // output stall. Allow several times that.
    localparam int unsigned LIMIT_NS = 6_000_000;

    // One row of the directed plan: a register write or a tick, optionally with a typed action.
    typedef struct packed {
        logic             is_write;
        logic [1:0]       reg_index;
        logic [21:0]      value;
        logic [1:0]       profile;
        logic             typed;
        pbc_pkg::result_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    pbc_cfg_if    cfg_ch ();
    pbc_tick_if   tick_ch ();
    pbc_action_if act_ch ();

    provisioning_backoff_controller_core #(
        .TICK_SECONDS (TICK_S),
        .MAX_ATTEMPTS (MAX_ATT)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .tick   (tick_ch),
        .action (act_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register shadow, at reset values.
    logic        reg_enable      = 1'b0;
    logic [15:0] reg_init_wait   = pbc_pkg::INITIAL_WAIT_RESET;
    logic [15:0] reg_enable_wait = pbc_pkg::ENABLE_WAIT_RESET;
    logic [21:0] reg_max_wait    = pbc_pkg::MAX_WAIT_RESET;

    // Controller state as the predictor sees it.
    pbc_pkg::phase_t ctl_phase   = pbc_pkg::PH_INITIAL;
    logic [31:0]     ctl_ticks   = '0;
    logic [4:0]      ctl_attempt = pbc_pkg::ATTEMPT_RESET;
    logic [31:0]     ctl_backoff = '0;

    pbc_pkg::result_t pending_actions [$];   // actions owed by the block, oldest first
    int      errors = 0;
    logic    calm   = 1'b0;         // when set, neither side idles

    // Registers take only their low bits; anything above is dropped.
    function automatic void apply_write(input logic [1:0] idx, input logic [21:0] val);
        case (idx)
            pbc_pkg::CFG_BLOCK_ENABLE: reg_enable      = val[0];
            pbc_pkg::CFG_INITIAL_WAIT: reg_init_wait   = val[15:0];
            pbc_pkg::CFG_ENABLE_WAIT:  reg_enable_wait = val[15:0];
            default:                   reg_max_wait    = val;
        endcase
    endfunction

    // One tick of the controller. Phase logic uses the count from before the tick, the
    // operational override follows, then the count steps and saturates.
    function automatic pbc_pkg::result_t advance_controller(input logic [1:0] prof);
        pbc_pkg::result_t r;
        logic [31:0] t;
        logic [31:0] init_judge;
        logic [31:0] enable_judge;
        logic [63:0] period_s;
        logic [63:0] period_ticks;
        r = '0;
        t = ctl_ticks;
        if (reg_enable)
        begin
            init_judge   = 32'(reg_init_wait) / TICK_S;
            enable_judge = 32'(reg_enable_wait) / TICK_S;
            case (ctl_phase)
                pbc_pkg::PH_ENABLE:
                begin
                    // First tick after entering: switch network on and ask for a new seed.
                    if (t == 32'd1)
                    begin
                        r.network_enable      = 1'b1;
                        r.request_seed_update = 1'b1;
                    end
                    else if (t >= enable_judge && prof == pbc_pkg::PROF_PROV)
                    begin
                        ctl_phase = pbc_pkg::PH_NEXT;
                        t         = '0;
                    end
                end
                pbc_pkg::PH_NEXT:
                begin
                    if (t == 32'd1)
                    begin
                        // Backoff: 2^(n-1) * base + enable wait, in seconds.
                        period_s = (64'(reg_init_wait) << (ctl_attempt - 5'd1))
                                   + 64'(reg_enable_wait);
                        period_ticks = period_s / TICK_S;
                        ctl_backoff  = (period_ticks > 64'hFFFF_FFFF)
                                       ? pbc_pkg::TICK_COUNT_MAX : period_ticks[31:0];
                        if (period_s > 64'(reg_max_wait))
                        begin
                            ctl_phase   = pbc_pkg::PH_INITIAL;
                            t           = '0;
                            ctl_attempt = pbc_pkg::ATTEMPT_RESET;
                        end
                        else
                        begin
                            r.network_disable      = 1'b1;
                            r.request_card_disable = 1'b1;
                            if (ctl_attempt < MAX_ATT)
                                ctl_attempt = ctl_attempt + 5'd1;
                        end
                    end
                    if (t > ctl_backoff)
                    begin
                        ctl_phase = pbc_pkg::PH_ENABLE;
                        t         = '0;
                    end
                end
                default:
                begin
                    // Initial wait; the unused phase code lands here too.
                    ctl_phase = pbc_pkg::PH_INITIAL;
                    if (t >= init_judge)
                    begin
                        if (prof == pbc_pkg::PROF_PROV)
                            ctl_phase = pbc_pkg::PH_NEXT;
                        else if (prof != pbc_pkg::PROF_OPER)
                            ctl_phase = pbc_pkg::PH_ENABLE;
                        t = '0;
                    end
                end
            endcase
            if (prof == pbc_pkg::PROF_OPER)
            begin
                r.network_enable = 1'b1;
                t                = '0;
            end
            if (t != pbc_pkg::TICK_COUNT_MAX)
                t = t + 32'd1;
            ctl_ticks = t;
        end
        r.phase_now = ctl_phase;
        return r;
    endfunction

    // Mostly no gap, some short, a few long.
    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic pbc_pkg::result_t act(input logic en, input logic dis, input logic seed,
                                             input logic cdis, input pbc_pkg::phase_t ph);
        pbc_pkg::result_t r;
        r.network_enable       = en;
        r.network_disable      = dis;
        r.request_seed_update  = seed;
        r.request_card_disable = cdis;
        r.phase_now            = ph;
        return r;
    endfunction

    function automatic plan_row_t wr(input logic [1:0] idx, input logic [21:0] val);
        plan_row_t r;
        r           = '0;
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.value     = val;
        return r;
    endfunction

    function automatic plan_row_t tk(input logic [1:0] prof);
        plan_row_t r;
        r         = '0;
        r.profile = prof;
        return r;
    endfunction

    function automatic plan_row_t tkx(input logic [1:0] prof, input pbc_pkg::result_t want);
        plan_row_t r;
        r       = tk(prof);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // Holds a profile for a burst of ticks so phases get a chance to play out;
    // single-tick bursts act as noise.
    logic [1:0] burst_prof = pbc_pkg::PROF_OTHER;
    int         burst_left = 0;

    function automatic logic [1:0] next_profile();
        int r;
        if (burst_left == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                burst_prof = pbc_pkg::PROF_PROV;
            else if (r < 75)
                burst_prof = pbc_pkg::PROF_OTHER;
            else if (r < 88)
                burst_prof = pbc_pkg::PROF_OPER;
            else
                burst_prof = 2'd3;
            burst_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
        end
        burst_left--;
        return burst_prof;
    endfunction

    // Tick transaction. valid stays high between back-to-back ticks; it is only lowered
    // when a gap is taken, so it never toggles within one step.
    task automatic send_tick(input logic [1:0] prof, input logic typed,
                             input pbc_pkg::result_t want);
        int               gap;
        pbc_pkg::result_t pred;
        gap = gap_len();
        if (gap != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.profile_type <= prof;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        pred = advance_controller(prof);
        pending_actions.push_back(typed ? want : pred);
    endtask

    // Register write; caller lowers valid after the last of a series.
    task automatic write_reg(input logic [1:0] idx, input logic [21:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        apply_write(idx, val);
    endtask

    // Every tick yields one action, so an empty queue means the block is idle.
    task automatic settle();
        while (pending_actions.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [1:0] want,
                                 input logic [1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Output side: random back-pressure once reset is released.
    initial
    begin : action_sink
        int n;
        act_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            n = gap_len();
            if (n != 0)
            begin
                act_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            act_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : action_check
        pbc_pkg::result_t want;
        if (rst_n && act_ch.valid && act_ch.ready)
        begin
            if (pending_actions.size() == 0)
            begin
                $display("%0t: unexpected action, expected none actual %b%b%b%b phase %0d",
                         $time, act_ch.network_enable, act_ch.network_disable,
                         act_ch.request_seed_update, act_ch.request_card_disable,
                         act_ch.phase_now);
                errors++;
            end
            else
            begin
                want = pending_actions.pop_front();
                compare_field("network_enable", 2'(want.network_enable),
                              2'(act_ch.network_enable));
                compare_field("network_disable", 2'(want.network_disable),
                              2'(act_ch.network_disable));
                compare_field("request_seed_update", 2'(want.request_seed_update),
                              2'(act_ch.request_seed_update));
                compare_field("request_card_disable", 2'(want.request_card_disable),
                              2'(act_ch.request_card_disable));
                compare_field("phase_now", want.phase_now, act_ch.phase_now);
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t   plan [$];
        int          total;
        int          phase_len;
        int          p;
        int          k;
        logic        en;
        logic [15:0] iw;
        logic [15:0] ew;
        logic [21:0] mw;

        tick_ch.valid        <= 1'b0;
        tick_ch.profile_type <= pbc_pkg::PROF_OTHER;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= pbc_pkg::CFG_BLOCK_ENABLE;
        cfg_ch.data          <= '0;
        rst_n                <= 1'b0;

        // Disabled after reset: nothing happens, operational and code three included.
        plan.push_back(tkx(pbc_pkg::PROF_OTHER,
                           act(1'b0, 1'b0, 1'b0, 1'b0, pbc_pkg::PH_INITIAL)));
        plan.push_back(tkx(pbc_pkg::PROF_OPER,
                           act(1'b0, 1'b0, 1'b0, 1'b0, pbc_pkg::PH_INITIAL)));
        plan.push_back(tkx(2'd3, act(1'b0, 1'b0, 1'b0, 1'b0, pbc_pkg::PH_INITIAL)));
        // Zero waits, widest limit: every phase turns over in a few ticks.
        plan.push_back(wr(pbc_pkg::CFG_INITIAL_WAIT, 22'd0));
        plan.push_back(wr(pbc_pkg::CFG_ENABLE_WAIT, 22'd0));
        plan.push_back(wr(pbc_pkg::CFG_MAX_WAIT, 22'h3F_FFFF));
        plan.push_back(wr(pbc_pkg::CFG_BLOCK_ENABLE, 22'd1));
        plan.push_back(tkx(pbc_pkg::PROF_OTHER,
                           act(1'b0, 1'b0, 1'b0, 1'b0, pbc_pkg::PH_ENABLE)));
        // first tick of wait enable; code three counts as other
        plan.push_back(tkx(2'd3, act(1'b1, 1'b0, 1'b1, 1'b0, pbc_pkg::PH_ENABLE)));
        plan.push_back(tk(pbc_pkg::PROF_PROV));    // to wait next
        plan.push_back(tk(pbc_pkg::PROF_OTHER));   // disable network and card
        plan.push_back(tk(pbc_pkg::PROF_OPER));
        plan.push_back(tk(pbc_pkg::PROF_PROV));
        plan.push_back(tk(pbc_pkg::PROF_PROV));
        plan.push_back(tk(pbc_pkg::PROF_OPER));    // disable and enable on the same tick
        // Backoff above the limit sends the controller back to initial wait.
        plan.push_back(wr(pbc_pkg::CFG_INITIAL_WAIT, 22'd15));
        plan.push_back(wr(pbc_pkg::CFG_MAX_WAIT, 22'd0));
        plan.push_back(tk(pbc_pkg::PROF_PROV));
        plan.push_back(tk(pbc_pkg::PROF_PROV));
        plan.push_back(tk(pbc_pkg::PROF_OTHER));
        plan.push_back(tk(pbc_pkg::PROF_OTHER));
        plan.push_back(tk(pbc_pkg::PROF_OPER));
        // Largest waits.
        plan.push_back(wr(pbc_pkg::CFG_ENABLE_WAIT, 22'h00_FFFF));
        plan.push_back(wr(pbc_pkg::CFG_INITIAL_WAIT, 22'h00_FFFF));
        plan.push_back(wr(pbc_pkg::CFG_MAX_WAIT, 22'h3F_FFFF));
        plan.push_back(tk(pbc_pkg::PROF_PROV));
        plan.push_back(tk(pbc_pkg::PROF_PROV));
        plan.push_back(tk(pbc_pkg::PROF_OPER));
        // Disabled again: phase is held, no pulses.
        plan.push_back(wr(pbc_pkg::CFG_BLOCK_ENABLE, 22'd0));
        plan.push_back(tkx(pbc_pkg::PROF_PROV,
                           act(1'b0, 1'b0, 1'b0, 1'b0, pbc_pkg::PH_ENABLE)));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                if (i == 0 || !plan[i-1].is_write)
                begin
                    tick_ch.valid <= 1'b0;
                    settle();
                end
                write_reg(plan[i].reg_index, plan[i].value);
            end
            else
            begin
                if (i > 0 && plan[i-1].is_write)
                    cfg_ch.valid <= 1'b0;
                send_tick(plan[i].profile, plan[i].typed, plan[i].want);
            end
        end

        // Random part: a run of register settings, each followed by a burst of ticks.
        total = 0;
        p     = 0;
        while (total < RUN_ITEMS)
        begin
            tick_ch.valid <= 1'b0;
            settle();
            calm = ($urandom_range(0, 4) == 0);
            if (p == 0)
            begin
                // zero waits, widest limit: attempt count climbs to saturation
                en        = 1'b1;
                iw        = '0;
                ew        = '0;
                mw        = 22'h3F_FFFF;
                phase_len = 300;
            end
            else if (p == 1)
            begin
                // top of every field, limit at zero
                en        = 1'b1;
                iw        = 16'hFFFF;
                ew        = 16'hFFFF;
                mw        = '0;
                phase_len = 40;
            end
            else
            begin
                en = ($urandom_range(0, 9) != 0);
                case ($urandom_range(0, 3))
                    0:       iw = '0;
                    3:       iw = 16'($urandom_range(0, 16'hFFFF));
                    default: iw = 16'($urandom_range(1, 300));
                endcase
                case ($urandom_range(0, 3))
                    0:       ew = '0;
                    3:       ew = 16'($urandom_range(0, 16'hFFFF));
                    default: ew = 16'($urandom_range(1, 150));
                endcase
                case ($urandom_range(0, 3))
                    0:       mw = '0;
                    1:       mw = 22'($urandom_range(0, 3000));
                    2:       mw = 22'($urandom_range(0, 22'h3F_FFFF));
                    default: mw = 22'h3F_FFFF;
                endcase
                phase_len = $urandom_range(60, 180);
            end
            // junk above the width of the wait and block enable registers must be ignored
            write_reg(pbc_pkg::CFG_INITIAL_WAIT, {6'($urandom), iw});
            write_reg(pbc_pkg::CFG_ENABLE_WAIT, {6'($urandom), ew});
            write_reg(pbc_pkg::CFG_MAX_WAIT, mw);
            write_reg(pbc_pkg::CFG_BLOCK_ENABLE, {21'($urandom), en});
            cfg_ch.valid <= 1'b0;
            for (k = 0; k < phase_len; k++)
                send_tick(next_profile(), 1'b0, '0);
            total += phase_len;
            p++;
        end

        tick_ch.valid <= 1'b0;
        settle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("tb: FAIL");
        $finish;
    end

endmodule
